/* rtl/plucked_string_synth_top_defines.svh */
// Assertion macros for the plucked string voice.
// Each check is sampled on clk and disabled while arst_n is low.
`ifndef PLUCKED_STRING_SYNTH_TOP_DEFINES_SVH
`define PLUCKED_STRING_SYNTH_TOP_DEFINES_SVH

`ifndef SYNTH
`define PSS_ASSERT_IMPLIES(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("pss: same-cycle check failed");
`define PSS_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("pss: next-cycle check failed");
`else
`define PSS_ASSERT_IMPLIES(label, ante, cons)
`define PSS_ASSERT_NEXT(label, ante, cons)
`endif

`endif

/* rtl/pss_pkg.sv */
package pss_pkg;

	// Delay line geometry and sample format
	localparam int LINE_DEPTH  = 4096;
	localparam int ADDR_BITS   = $clog2(LINE_DEPTH);
	localparam int SAMPLE_BITS = 16;
	localparam int SAT_BITS    = SAMPLE_BITS + 2;

	// Field widths
	localparam int DL_BITS     = 12;
	localparam int VEL_BITS    = 15;
	localparam int BRIGHT_BITS = 16;
	localparam int DAMP_BITS   = 16;
	localparam int SEED_BITS   = 32;
	localparam int GAIN_BITS   = 16;
	localparam int COEF_BITS   = 16;

	// Product widths
	localparam int DPROD_BITS = (SAMPLE_BITS + 1) + (COEF_BITS + 1);
	localparam int VPROD_BITS = SAMPLE_BITS + VEL_BITS + 1;
	localparam int TPROD_BITS = (SAMPLE_BITS + 1) + (GAIN_BITS + 1);

	// Fraction bits of the rounding shifts
	localparam int COEF_FRAC = 16;
	localparam int VEL_FRAC  = 14;
	localparam int GAIN_FRAC = 17;

	// Q0.16 constants: 0.15, 0.82, 0.997, 0.28
	localparam int COEF_BASE  = 9830;
	localparam int BRIGHT_MUL = 53740;
	localparam int GAIN_BASE  = 65339;
	localparam int DAMP_MUL   = 18350;

	localparam int MIN_PERIOD = 2;

	localparam logic [SEED_BITS-1:0] LFSR_TAPS     = 32'h8020_0003;
	localparam logic [SEED_BITS-1:0] SEED_RESET    = 32'd1;
	localparam logic [DAMP_BITS-1:0] DAMPING_RESET = 16'd19661;

	// APB register map
	localparam int PADDR_BITS = 3;
	localparam int PDATA_BITS = 32;
	localparam logic REG_DAMPING = 1'b0;
	localparam logic REG_SEED    = 1'b1;

	localparam logic signed [SAT_BITS-1:0] SAT_HI = SAT_BITS'((1 <<< (SAMPLE_BITS - 1)) - 1);
	localparam logic signed [SAT_BITS-1:0] SAT_LO = SAT_BITS'(-(1 <<< (SAMPLE_BITS - 1)));

	typedef struct packed {
		logic [GAIN_BITS-1:0] gain;
		logic                 seed_wr;
		logic [SEED_BITS-1:0] seed;
	} cfg_t;

	typedef struct packed {
		logic                          we;
		logic [ADDR_BITS-1:0]          waddr;
		logic signed [SAMPLE_BITS-1:0] wdata;
		logic [ADDR_BITS-1:0]          raddr_a;
		logic [ADDR_BITS-1:0]          raddr_b;
	} ram_req_t;

	// Loop gain 0.997 - 0.28*damping, Q0.16, rounded half up
	function automatic logic [GAIN_BITS-1:0] gain_of(input logic [DAMP_BITS-1:0] d);
		logic [31:0] prod;
		prod = 32'(DAMP_MUL) * 32'(d) + 32'(1 << (COEF_FRAC - 1));
		return GAIN_BITS'(32'(GAIN_BASE) - (prod >> COEF_FRAC));
	endfunction

	localparam logic [GAIN_BITS-1:0] GAIN_RESET = gain_of(DAMPING_RESET);

	function automatic logic [ADDR_BITS-1:0] clamp_period(input logic [DL_BITS-1:0] dl);
		logic [31:0] v;
		v = 32'(dl);
		if (v < 32'(MIN_PERIOD)) begin
			v = 32'(MIN_PERIOD);
		end
		if (v > 32'(LINE_DEPTH - 1)) begin
			v = 32'(LINE_DEPTH - 1);
		end
		return ADDR_BITS'(v);
	endfunction

	function automatic logic signed [SAMPLE_BITS-1:0] sat_sample(
		input logic signed [SAT_BITS-1:0] v);
		logic signed [SAT_BITS-1:0] r;
		r = v;
		if (v > SAT_HI) begin
			r = SAT_HI;
		end else if (v < SAT_LO) begin
			r = SAT_LO;
		end
		return r[SAMPLE_BITS-1:0];
	endfunction

endpackage

/* rtl/pss_ram.sv */
module pss_ram import pss_pkg::*; (
	input  logic                          clk,
	input  ram_req_t                      req,
	output logic signed [SAMPLE_BITS-1:0] rdata_a,
	output logic signed [SAMPLE_BITS-1:0] rdata_b
);

	logic signed [SAMPLE_BITS-1:0] mem_q [LINE_DEPTH];

	always_ff @(posedge clk) begin
		if (req.we) begin
			mem_q[req.waddr] <= req.wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata_a <= mem_q[req.raddr_a];
		rdata_b <= mem_q[req.raddr_b];
	end

endmodule

/* rtl/pss_regs.sv */
module pss_regs import pss_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [PADDR_BITS-1:0] paddr,
	input  logic [PDATA_BITS-1:0] pwdata,
	output logic [PDATA_BITS-1:0] prdata,
	output logic                  pready,
	output cfg_t                  cfg
);

	logic [DAMP_BITS-1:0] damping_q;
	logic [GAIN_BITS-1:0] gain_q;
	logic [SEED_BITS-1:0] seed_q;
	logic                 seed_wr_q;
	logic                 wr_en;
	logic                 reg_sel;

	assign pready  = 1'b1;
	assign wr_en   = psel && penable && pwrite && pready;
	assign reg_sel = paddr[2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			damping_q <= DAMPING_RESET;
			gain_q    <= GAIN_RESET;
			seed_q    <= SEED_RESET;
			seed_wr_q <= 1'b0;
		end else begin
			seed_wr_q <= 1'b0;
			if (wr_en) begin
				unique case (reg_sel)
					REG_DAMPING: begin
						damping_q <= pwdata[DAMP_BITS-1:0];
						gain_q    <= gain_of(pwdata[DAMP_BITS-1:0]);
					end
					REG_SEED: begin
						seed_q    <= pwdata[SEED_BITS-1:0];
						seed_wr_q <= 1'b1;
					end
					default: ;
				endcase
			end
		end
	end

	always_comb begin
		unique case (reg_sel)
			REG_DAMPING: prdata = PDATA_BITS'(damping_q);
			REG_SEED:    prdata = PDATA_BITS'(seed_q);
			default:     prdata = '0;
		endcase
	end

	// Seed reloads the noise register in the cycle after the write
	assign cfg.gain    = gain_q;
	assign cfg.seed_wr = seed_wr_q;
	assign cfg.seed    = seed_q;

endmodule

/* rtl/pss_core.sv */
module pss_core import pss_pkg::*; (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic                          action,
	input  logic [DL_BITS-1:0]            delay_length,
	input  logic [VEL_BITS-1:0]           velocity,
	input  logic [BRIGHT_BITS-1:0]        brightness,
	input  cfg_t                          cfg,
	output ram_req_t                      ram_req,
	input  logic signed [SAMPLE_BITS-1:0] rdata_a,
	input  logic signed [SAMPLE_BITS-1:0] rdata_b,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic signed [SAMPLE_BITS-1:0] sample
);

	localparam logic [3:0] ST_CLEAR = 4'd0;
	localparam logic [3:0] ST_IDLE  = 4'd1;
	localparam logic [3:0] ST_TRD   = 4'd2;
	localparam logic [3:0] ST_TMUL  = 4'd3;
	localparam logic [3:0] ST_TWR   = 4'd4;
	localparam logic [3:0] ST_PCOEF = 4'd5;
	localparam logic [3:0] ST_PNZ   = 4'd6;
	localparam logic [3:0] ST_PACC  = 4'd7;
	localparam logic [3:0] ST_PVEL  = 4'd8;
	localparam logic [3:0] ST_PWR   = 4'd9;

	logic [3:0]                    state_q;
	logic [ADDR_BITS-1:0]          wp_q;
	logic [ADDR_BITS-1:0]          rd_q;
	logic [ADDR_BITS-1:0]          period_q;
	logic [ADDR_BITS-1:0]          cnt_q;
	logic [ADDR_BITS-1:0]          clr_q;
	logic [SEED_BITS-1:0]          lfsr_q;
	logic [VEL_BITS-1:0]           vel_q;
	logic [BRIGHT_BITS-1:0]        bright_q;
	logic [COEF_BITS-1:0]          coef_q;
	logic signed [SAMPLE_BITS-1:0] filt_q;
	logic signed [SAMPLE_BITS-1:0] cur_s2;
	logic signed [TPROD_BITS-1:0]  prod_s2;
	logic signed [DPROD_BITS-1:0]  dprod_s1;
	logic signed [VPROD_BITS-1:0]  vprod_s2;
	logic                          out_valid_q;
	logic signed [SAMPLE_BITS-1:0] sample_q;

	logic                          in_acc;
	logic                          out_free;
	logic [ADDR_BITS-1:0]          period_w;
	logic [SEED_BITS-1:0]          lfsr_src;
	logic [SEED_BITS-1:0]          lfsr_nx;
	logic signed [SAMPLE_BITS-1:0] noise_w;
	logic signed [SAMPLE_BITS:0]   diff_w;
	logic signed [SAMPLE_BITS:0]   tsum_w;
	logic signed [TPROD_BITS-1:0]  trnd_w;
	logic signed [DPROD_BITS-1:0]  drnd_w;
	logic signed [VPROD_BITS-1:0]  vrnd_w;
	logic [31:0]                   coef_w;
	logic signed [SAMPLE_BITS-1:0] tick_wdata;
	logic signed [SAMPLE_BITS-1:0] pluck_wdata;

	assign in_stall = (state_q != ST_IDLE);
	assign in_acc   = in_valid && !in_stall;
	assign out_free = !out_valid_q || !out_stall;
	assign period_w = clamp_period(delay_length);

	// Galois LFSR step; a zero register restarts at one
	assign lfsr_src = (lfsr_q == '0) ? SEED_BITS'(1) : lfsr_q;
	assign lfsr_nx  = (lfsr_src >> 1) ^ (lfsr_src[0] ? LFSR_TAPS : '0);
	assign noise_w  = $signed({~lfsr_nx[SEED_BITS-1],
		lfsr_nx[SEED_BITS-2:SEED_BITS-SAMPLE_BITS]});
	assign diff_w   = (SAMPLE_BITS + 1)'(noise_w) - (SAMPLE_BITS + 1)'(filt_q);

	// Brightness never drives the coefficient outside [0.01, 1.0], so no clamp
	assign coef_w = 32'(COEF_BASE) + ((32'(BRIGHT_MUL) * 32'(bright_q)
		+ 32'(1 << (COEF_FRAC - 1))) >> COEF_FRAC);

	assign tsum_w = (SAMPLE_BITS + 1)'(rdata_a) + (SAMPLE_BITS + 1)'(rdata_b);
	assign trnd_w = prod_s2 + TPROD_BITS'(1 <<< (GAIN_FRAC - 1));
	assign drnd_w = dprod_s1 + DPROD_BITS'(1 <<< (COEF_FRAC - 1));
	assign vrnd_w = vprod_s2 + VPROD_BITS'(1 <<< (VEL_FRAC - 1));

	assign tick_wdata  = sat_sample(SAT_BITS'($signed(trnd_w[TPROD_BITS-1:GAIN_FRAC])));
	assign pluck_wdata = sat_sample(SAT_BITS'($signed(vrnd_w[VPROD_BITS-1:VEL_FRAC])));

	always_comb begin
		ram_req.we      = 1'b0;
		ram_req.waddr   = wp_q;
		ram_req.wdata   = tick_wdata;
		ram_req.raddr_a = rd_q;
		ram_req.raddr_b = rd_q + ADDR_BITS'(1);
		unique case (state_q)
			ST_CLEAR: begin
				ram_req.we    = 1'b1;
				ram_req.waddr = clr_q;
				ram_req.wdata = '0;
			end
			ST_TWR: begin
				ram_req.we = out_free;
			end
			ST_PWR: begin
				ram_req.we    = 1'b1;
				ram_req.waddr = wp_q + cnt_q;
				ram_req.wdata = pluck_wdata;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			wp_q        <= '0;
			clr_q       <= '0;
			cnt_q       <= '0;
			lfsr_q      <= SEED_RESET;
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			if (cfg.seed_wr) begin
				lfsr_q <= cfg.seed;
			end
			unique case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + ADDR_BITS'(1);
					if (clr_q == ADDR_BITS'(LINE_DEPTH - 1)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (in_acc) begin
						cnt_q   <= '0;
						state_q <= action ? ST_PCOEF : ST_TRD;
					end
				end
				ST_TRD:   state_q <= ST_TMUL;
				ST_TMUL:  state_q <= ST_TWR;
				ST_TWR: begin
					// hold until the output register is free
					if (out_free) begin
						out_valid_q <= 1'b1;
						wp_q        <= wp_q + ADDR_BITS'(1);
						state_q     <= ST_IDLE;
					end
				end
				ST_PCOEF: state_q <= ST_PNZ;
				ST_PNZ: begin
					lfsr_q  <= lfsr_nx;
					state_q <= ST_PACC;
				end
				ST_PACC:  state_q <= ST_PVEL;
				ST_PVEL:  state_q <= ST_PWR;
				ST_PWR: begin
					cnt_q <= cnt_q + ADDR_BITS'(1);
					if (cnt_q == period_q - ADDR_BITS'(1)) begin
						state_q <= ST_IDLE;
					end else begin
						state_q <= ST_PNZ;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Datapath registers
	always_ff @(posedge clk) begin
		if (in_acc) begin
			period_q <= period_w;
			rd_q     <= wp_q - period_w;
			vel_q    <= velocity;
			bright_q <= brightness;
			filt_q   <= '0;
		end
		if (state_q == ST_PCOEF) begin
			coef_q <= COEF_BITS'(coef_w);
		end
		if (state_q == ST_TMUL) begin
			cur_s2  <= rdata_a;
			prod_s2 <= TPROD_BITS'(tsum_w) * TPROD_BITS'($signed({1'b0, cfg.gain}));
		end
		if (state_q == ST_TWR && out_free) begin
			sample_q <= cur_s2;
		end
		if (state_q == ST_PNZ) begin
			dprod_s1 <= DPROD_BITS'(diff_w) * DPROD_BITS'($signed({1'b0, coef_q}));
		end
		if (state_q == ST_PACC) begin
			// the filter stays between its last value and the noise, so no overflow
			filt_q <= filt_q + $signed(drnd_w[COEF_FRAC+SAMPLE_BITS-1:COEF_FRAC]);
		end
		if (state_q == ST_PVEL) begin
			vprod_s2 <= VPROD_BITS'(filt_q) * VPROD_BITS'($signed({1'b0, vel_q}));
		end
	end

	assign out_valid = out_valid_q;
	assign sample    = sample_q;

endmodule

/* rtl/plucked_string_synth_top.sv */
// Karplus-Strong plucked string voice on a 4096-entry circular delay line of Q1.15 samples.
// A tick (action 0) returns the sample delay_length entries behind the write pointer and
// writes back the damped average of that sample and its successor; a pluck (action 1)
// refills delay_length entries with lowpassed, velocity-scaled LFSR noise and returns
// nothing. Both taps come from one two-read, one-write synchronous RAM. A tick steps
// through read, multiply and write-back states and back to idle, waiting in write-back
// while the previous result is still held by out_stall. A pluck computes its coefficient
// once, then for each of P entries, where P is delay_length raised to at least 2, runs
// the one-pole filter recurrence: noise/multiply, accumulate, velocity multiply and RAM
// write. After reset the RAM is zeroed one entry per cycle, all 4096 entries, with
// in_stall high; APB writes are taken throughout.
`include "plucked_string_synth_top_defines.svh"

module plucked_string_synth_top import pss_pkg::*; (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic                          action,
	input  logic [DL_BITS-1:0]            delay_length,
	input  logic [VEL_BITS-1:0]           velocity,
	input  logic [BRIGHT_BITS-1:0]        brightness,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic signed [SAMPLE_BITS-1:0] sample,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [PADDR_BITS-1:0]         paddr,
	input  logic [PDATA_BITS-1:0]         pwdata,
	output logic [PDATA_BITS-1:0]         prdata,
	output logic                          pready
);

	cfg_t                          cfg;
	ram_req_t                      ram_req;
	logic signed [SAMPLE_BITS-1:0] rdata_a;
	logic signed [SAMPLE_BITS-1:0] rdata_b;

	pss_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	pss_ram u_ram (
		.clk     (clk),
		.req     (ram_req),
		.rdata_a (rdata_a),
		.rdata_b (rdata_b)
	);

	pss_core u_core (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.action       (action),
		.delay_length (delay_length),
		.velocity     (velocity),
		.brightness   (brightness),
		.cfg          (cfg),
		.ram_req      (ram_req),
		.rdata_a      (rdata_a),
		.rdata_b      (rdata_b),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.sample       (sample)
	);

	`PSS_ASSERT_NEXT(a_busy_after_accept, in_valid && !in_stall, in_stall)
	`PSS_ASSERT_IMPLIES(a_ram_write_busy, ram_req.we, in_stall)
	`PSS_ASSERT_NEXT(a_pluck_no_result, in_valid && !in_stall && action, !$rose(out_valid))

endmodule

/* sim/tb_plucked_string_synth_top.sv */
`timescale 1ns / 1ps

module tb_plucked_string_synth_top import pss_pkg::*; ();

	localparam int CLK_PERIOD     = 10;
	localparam int WATCHDOG_LIMIT = 100000;
	localparam int SETTLE_CYCLES  = 4 * LINE_DEPTH + 16;

	localparam logic ACT_TICK  = 1'b0;
	localparam logic ACT_PLUCK = 1'b1;

	class voice_scoreboard;
		logic signed [SAMPLE_BITS-1:0] line_mem [LINE_DEPTH];
		logic [ADDR_BITS-1:0]          wr_ptr;
		logic [SEED_BITS-1:0]          lfsr;
		logic [DAMP_BITS-1:0]          damping;
		logic signed [SAMPLE_BITS-1:0] expected_samples [$];
		int                            errors;

		function new();
			foreach (line_mem[i]) line_mem[i] = '0;
			wr_ptr  = '0;
			lfsr    = SEED_RESET;
			damping = DAMPING_RESET;
			errors  = 0;
		endfunction

		// floor((v + 2^(s-1)) / 2^s)
		function longint round_shift(longint v, int s);
			return (v + (longint'(1) <<< (s - 1))) >>> s;
		endfunction

		function logic signed [SAMPLE_BITS-1:0] clip_sample(longint v);
			longint hi;
			hi = (longint'(1) <<< (SAMPLE_BITS - 1)) - 1;
			if (v > hi) return SAMPLE_BITS'(hi);
			if (v < -hi - 1) return SAMPLE_BITS'(-hi - 1);
			return SAMPLE_BITS'(v);
		endfunction

		function longint noise_step();
			logic lsb;
			if (lfsr == '0) lfsr = SEED_BITS'(1);
			lsb  = lfsr[0];
			lfsr = lfsr >> 1;
			if (lsb) lfsr = lfsr ^ LFSR_TAPS;
			return longint'(lfsr[SEED_BITS-1 -: SAMPLE_BITS]) - (longint'(1) <<< (SAMPLE_BITS - 1));
		endfunction

		function void apply_register(logic idx, logic [PDATA_BITS-1:0] value);
			if (idx == REG_DAMPING) begin
				damping = value[DAMP_BITS-1:0];
			end else begin
				lfsr = value[SEED_BITS-1:0];
			end
		endfunction

		function void absorb_item(logic act, logic [DL_BITS-1:0] dl, logic [VEL_BITS-1:0] vel,
			logic [BRIGHT_BITS-1:0] bright);
			int                   span;
			int                   i;
			longint               coef;
			longint               filt;
			longint               cur;
			longint               nxt;
			longint               gain;
			logic [ADDR_BITS-1:0] rd;
			span = (int'(dl) < MIN_PERIOD) ? MIN_PERIOD : int'(dl);
			if (span > LINE_DEPTH - 1) span = LINE_DEPTH - 1;
			if (act == ACT_PLUCK) begin
				coef = COEF_BASE + round_shift(BRIGHT_MUL * longint'(bright), COEF_FRAC);
				if (coef < 655) coef = 655;
				if (coef > 65536) coef = 65536;
				filt = 0;
				for (i = 0; i < span; i++) begin
					filt += round_shift(coef * (noise_step() - filt), COEF_FRAC);
					line_mem[ADDR_BITS'(wr_ptr + i)] =
						clip_sample(round_shift(filt * longint'(vel), VEL_FRAC));
				end
			end else begin
				rd   = wr_ptr - ADDR_BITS'(span);
				cur  = line_mem[rd];
				nxt  = line_mem[ADDR_BITS'(rd + 1)];
				gain = GAIN_BASE - round_shift(DAMP_MUL * longint'(damping), COEF_FRAC);
				line_mem[wr_ptr] = clip_sample(round_shift((cur + nxt) * gain, GAIN_FRAC));
				expected_samples.push_back(SAMPLE_BITS'(cur));
				wr_ptr = wr_ptr + 1'b1;
			end
		endfunction

		task report_mismatch(input string what);
			$display("[%0t] mismatch: %s", $realtime, what);
			errors++;
		endtask

		task check_sample(input logic signed [SAMPLE_BITS-1:0] got);
			logic signed [SAMPLE_BITS-1:0] want;
			if (expected_samples.size() == 0) begin
				report_mismatch($sformatf("sample %0d with no tick pending", got));
			end else begin
				want = expected_samples.pop_front();
				if (got !== want) begin
					report_mismatch($sformatf("sample got %0d, want %0d", got, want));
				end
			end
		endtask
	endclass

	logic                          clk          = 1'b0;
	logic                          arst_n       = 1'b0;
	logic                          in_valid     = 1'b0;
	logic                          in_stall;
	logic                          action       = ACT_TICK;
	logic [DL_BITS-1:0]            delay_length = '0;
	logic [VEL_BITS-1:0]           velocity     = '0;
	logic [BRIGHT_BITS-1:0]        brightness   = '0;
	logic                          out_valid;
	logic                          out_stall    = 1'b0;
	logic signed [SAMPLE_BITS-1:0] sample;
	logic                          psel         = 1'b0;
	logic                          penable      = 1'b0;
	logic                          pwrite       = 1'b0;
	logic [PADDR_BITS-1:0]         paddr        = '0;
	logic [PDATA_BITS-1:0]         pwdata       = '0;
	logic [PDATA_BITS-1:0]         prdata;
	logic                          pready;

	voice_scoreboard sb;
	int send_idle = 0;
	int recv_idle = 0;
	int quiet_cycles = 0;

	plucked_string_synth_top DUT (.*);

	always #(CLK_PERIOD / 2) clk = ~clk;

	always @(negedge clk) begin
		out_stall <= ($urandom_range(99) < recv_idle);
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) sb.check_sample(sample);
	end

	always @(posedge clk) begin
		if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("RESULT: ERROR");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	// called and returns on a falling edge
	task automatic send_item(input logic act, input logic [DL_BITS-1:0] dl,
		input logic [VEL_BITS-1:0] vel, input logic [BRIGHT_BITS-1:0] bright);
		while ($urandom_range(99) < send_idle) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid     <= 1'b1;
		action       <= act;
		delay_length <= dl;
		velocity     <= vel;
		brightness   <= bright;
		do @(posedge clk); while (in_stall);
		sb.absorb_item(act, dl, vel, bright);
		@(negedge clk);
	endtask

	// leave the bus idle before returning
	task automatic apb_write(input logic idx, input logic [PDATA_BITS-1:0] value);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= value;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		sb.apply_register(idx, value);
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		@(negedge clk);
	endtask

	// drop valid, wait out pending ticks and any pluck still filling the line
	task automatic drain();
		in_valid <= 1'b0;
		while (sb.expected_samples.size() != 0) @(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic reconfigure(input logic [DAMP_BITS-1:0] damp, input logic [SEED_BITS-1:0] seed);
		drain();
		apb_write(REG_DAMPING, PDATA_BITS'(damp));
		apb_write(REG_SEED, PDATA_BITS'(seed));
	endtask

	task automatic random_burst(input int quota);
		int                 sent;
		int                 ticks;
		int                 span;
		int                 ahead;
		int                 pick;
		int                 k;
		logic [DL_BITS-1:0] dl;
		sent = 0;
		while (sent < quota) begin
			if ($urandom_range(99) < 80) begin
				// pluck, then ticks that read the fresh noise, loop on it, or jump anywhere
				span = ($urandom_range(59) == 0) ? $urandom_range(1024, LINE_DEPTH - 1)
					: $urandom_range(0, 48);
				send_item(ACT_PLUCK, DL_BITS'(span), VEL_BITS'($urandom), BRIGHT_BITS'($urandom));
				ticks = $urandom_range(1, 30);
				for (k = 0; k < ticks; k++) begin
					pick  = $urandom_range(9);
					ahead = span - 1 - k;
					if (pick < 5) begin
						dl = DL_BITS'(LINE_DEPTH - $urandom_range(1, (ahead > 1) ? ahead : 1));
					end else if (pick < 8) begin
						dl = DL_BITS'(span);
					end else begin
						dl = DL_BITS'($urandom);
					end
					send_item(ACT_TICK, dl, VEL_BITS'($urandom), BRIGHT_BITS'($urandom));
				end
				sent += ticks + 1;
			end else begin
				if ($urandom_range(3) == 0) begin
					send_item(ACT_PLUCK, DL_BITS'($urandom_range(0, 15)), VEL_BITS'($urandom),
						BRIGHT_BITS'($urandom));
				end else begin
					send_item(ACT_TICK, DL_BITS'($urandom), VEL_BITS'($urandom),
						BRIGHT_BITS'($urandom));
				end
				sent++;
			end
		end
		send_item(ACT_TICK, DL_BITS'($urandom), VEL_BITS'($urandom), BRIGHT_BITS'($urandom));
	endtask

	initial begin
		sb = new();
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// periods below two clamp; reads of a cleared line
		send_item(ACT_TICK, 12'd0, 15'd0, 16'd0);
		send_item(ACT_TICK, 12'd1, 15'h7FFF, 16'hFFFF);
		send_item(ACT_TICK, 12'd2, 15'd0, 16'd0);
		// whole line, full velocity and brightness: saturates
		send_item(ACT_PLUCK, 12'd4095, 15'h7FFF, 16'hFFFF);
		send_item(ACT_TICK, 12'd4095, 15'd0, 16'd0);
		send_item(ACT_TICK, 12'd4095, 15'd0, 16'd0);
		send_item(ACT_TICK, 12'd2, 15'd0, 16'd0);
		send_item(ACT_TICK, 12'd3, 15'd0, 16'd0);
		send_item(ACT_TICK, 12'd2048, 15'd0, 16'd0);
		// dark pluck at clamped period
		send_item(ACT_PLUCK, 12'd0, 15'd16384, 16'd0);
		send_item(ACT_TICK, 12'd4095, 15'd0, 16'd0);
		send_item(ACT_TICK, 12'd4094, 15'd0, 16'd0);
		// silent pluck
		send_item(ACT_PLUCK, 12'd1, 15'd0, 16'h8000);
		send_item(ACT_TICK, 12'd4095, 15'd0, 16'd0);
		send_item(ACT_PLUCK, 12'd40, 15'd1, 16'h0001);
		send_item(ACT_TICK, 12'd4090, 15'd0, 16'd0);
		send_item(ACT_TICK, 12'd4060, 15'd0, 16'd0);
		send_item(ACT_PLUCK, 12'd64, 15'h7FFF, 16'd0);
		send_item(ACT_TICK, 12'd4094, 15'd0, 16'd0);
		send_item(ACT_TICK, 12'd64, 15'd0, 16'd0);
		send_item(ACT_TICK, 12'd64, 15'd0, 16'd0);
		send_item(ACT_TICK, 12'd4095, 15'd0, 16'd0);

		// heavy damping, zero seed
		reconfigure(16'hFFFF, 32'd0);
		send_idle = 14;
		recv_idle = 88;
		random_burst(645);

		reconfigure(16'd0, 32'hFFFF_FFFF);
		send_idle = 88;
		recv_idle = 14;
		random_burst(645);

		reconfigure(DAMP_BITS'($urandom), SEED_BITS'($urandom));
		send_idle = 0;
		recv_idle = 0;
		random_burst(645);

		drain();
		if (sb.expected_samples.size() != 0) begin
			sb.report_mismatch($sformatf("%0d samples never arrived", sb.expected_samples.size()));
		end
		if (sb.errors == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("RESULT: ERROR");
		end
		$finish;
	end

endmodule
